// ===== sv/mgsp_pkg.sv =====
// Shared types and constants for the multistage graph shortest path unit.
// Used by every module of the block except mgsp_ram; depends on nothing.
`timescale 1ns / 1ps

package mgsp_pkg;

  // Fixed field widths of the ports
  localparam int INDEX_BITS       = 5;
  localparam int WEIGHT_IN_BITS   = 16;
  localparam int COUNT_BITS       = 6;
  localparam int DIST_BITS        = 21;

  // Distance saturation point and register reset value
  localparam logic [DIST_BITS-1:0]  DIST_MAX         = {DIST_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] NODE_COUNT_RESET = COUNT_BITS'(8);
  localparam int                    MIN_NODES        = 2;

  // Defaults for the top-level parameters
  localparam int MAX_NODES_DEFAULT   = 32;
  localparam int WEIGHT_BITS_DEFAULT = 16;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INIT,
    ST_ROW,
    ST_DRAIN,
    ST_STORE,
    ST_DONE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic clr_step;   // write one absent entry of the clearing pass
    logic load_wr;    // write the accepted edge entry
    logic init;       // zero the last node, set up the first row
    logic issue;      // read edge (i,j) and distance j
    logic j_step;     // advance the successor index
    logic store;      // write the row minimum into node i
    logic i_step;     // move to the previous row
    logic out_load;   // capture node 0's distance into the output register
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clr_last;   // clearing pass at the final entry
    logic j_last;     // successor index at the last node
    logic i_zero;     // current row is node 0
    logic out_free;   // output register can take a new result
  } dp_status_t;

endpackage

// ===== sv/mgsp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mgsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/mgsp_ctrl.sv =====
// Sequencing state machine: clearing pass, load writes, and the backward
// row/successor sweep of a solve. Depends on mgsp_pkg.
`timescale 1ns / 1ps

module mgsp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                solve_req,
  input  mgsp_pkg::dp_status_t status,
  output logic                in_stall,
  output mgsp_pkg::ctrl_cmd_t cmd
);

  import mgsp_pkg::*;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (status.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid && solve_req) state_next = ST_INIT;
      end
      ST_INIT: state_next = ST_ROW;
      ST_ROW: begin
        if (status.j_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_STORE;
      ST_STORE: begin
        state_next = status.i_zero ? ST_DONE : ST_ROW;
      end
      ST_DONE: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_CLEAR: cmd.clr_step = 1'b1;
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_wr = in_valid && !solve_req;
      end
      ST_INIT: cmd.init = 1'b1;
      ST_ROW: begin
        cmd.issue  = 1'b1;
        cmd.j_step = !status.j_last;
      end
      ST_DRAIN: ;
      ST_STORE: begin
        cmd.store  = 1'b1;
        cmd.i_step = !status.i_zero;
      end
      ST_DONE: cmd.out_load = status.out_free;
      default: ;
    endcase
  end

endmodule

// ===== sv/mgsp_datapath.sv =====
// Datapath: node_count register, edge matrix and node distance memories,
// row/successor counters, saturating add-compare, output register.
// Depends on mgsp_pkg and mgsp_ram.
`timescale 1ns / 1ps

module mgsp_datapath #(
  parameter int MAX_NODES   = mgsp_pkg::MAX_NODES_DEFAULT,
  parameter int WEIGHT_BITS = mgsp_pkg::WEIGHT_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [mgsp_pkg::COUNT_BITS-1:0]     cfg_wr_data,
  input  logic [mgsp_pkg::INDEX_BITS-1:0]     row_index,
  input  logic [mgsp_pkg::INDEX_BITS-1:0]     col_index,
  input  logic [mgsp_pkg::WEIGHT_IN_BITS-1:0] edge_weight,
  input  logic                                edge_absent,
  input  mgsp_pkg::ctrl_cmd_t                 cmd,
  output mgsp_pkg::dp_status_t                status,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mgsp_pkg::DIST_BITS-1:0]      shortest_distance,
  output logic                                unreachable
);

  import mgsp_pkg::*;

  localparam int NW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int DEPTH = MAX_NODES * MAX_NODES;
  localparam int AW    = $clog2(DEPTH);
  localparam int EW    = WEIGHT_BITS + 1;
  localparam int DW    = DIST_BITS + 1;
  localparam int SW    = ((WEIGHT_BITS > DIST_BITS) ? WEIGHT_BITS : DIST_BITS) + 1;

  logic [COUNT_BITS-1:0] node_count;
  logic [NW-1:0]         last_node;
  logic [NW-1:0]         row_cnt;
  logic [NW-1:0]         succ_cnt;
  logic [AW-1:0]         clr_addr;
  logic                  rd_valid;
  logic [DIST_BITS-1:0]  best;
  logic                  best_inf;

  logic                  edge_we;
  logic [AW-1:0]         edge_waddr;
  logic [EW-1:0]         edge_wdata;
  logic [AW-1:0]         edge_raddr;
  logic [EW-1:0]         edge_rdata;
  logic                  dist_we;
  logic [NW-1:0]         dist_waddr;
  logic [DW-1:0]         dist_wdata;
  logic [DW-1:0]         dist_rdata;

  logic                  load_in_range;
  logic [AW-1:0]         load_addr;
  logic [SW-1:0]         sum;
  logic [DIST_BITS-1:0]  sum_sat;
  logic                  cand_ok;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RESET;
    end else if (cfg_wr_en) begin
      node_count <= cfg_wr_data;
    end
  end

  // Destination node, node_count clamped to the supported range
  always_comb begin
    if (node_count < COUNT_BITS'(MIN_NODES)) begin
      last_node = NW'(1);
    end else if (32'(node_count) > MAX_NODES) begin
      last_node = NW'(MAX_NODES - 1);
    end else begin
      last_node = NW'(node_count - 1'b1);
    end
  end

  // Load address; entries outside the matrix are dropped
  assign load_in_range = (32'(row_index) < MAX_NODES) && (32'(col_index) < MAX_NODES);
  assign load_addr     = AW'(NW'(row_index)) * AW'(MAX_NODES) + AW'(NW'(col_index));

  // Edge matrix write port: clearing pass or load
  always_comb begin
    edge_we    = 1'b0;
    edge_waddr = clr_addr;
    edge_wdata = {1'b1, {WEIGHT_BITS{1'b0}}};
    if (cmd.clr_step) begin
      edge_we = 1'b1;
    end else if (cmd.load_wr && load_in_range) begin
      edge_we    = 1'b1;
      edge_waddr = load_addr;
      edge_wdata = edge_absent ? {1'b1, {WEIGHT_BITS{1'b0}}}
                               : {1'b0, WEIGHT_BITS'(edge_weight)};
    end
  end

  assign edge_raddr = AW'(row_cnt) * AW'(MAX_NODES) + AW'(succ_cnt);

  mgsp_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (edge_waddr),
    .wdata (edge_wdata),
    .raddr (edge_raddr),
    .rdata (edge_rdata)
  );

  // Distance write port: destination zero or row minimum
  assign dist_we    = cmd.init || cmd.store;
  assign dist_waddr = cmd.init ? last_node : row_cnt;
  assign dist_wdata = cmd.init ? '0 : {best_inf, best};

  mgsp_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_NODES)
  ) u_dist_ram (
    .clk   (clk),
    .we    (dist_we),
    .waddr (dist_waddr),
    .wdata (dist_wdata),
    .raddr (succ_cnt),
    .rdata (dist_rdata)
  );

  // Clearing-pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Row and successor counters
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      row_cnt  <= last_node - 1'b1;
      succ_cnt <= last_node;
    end else if (cmd.i_step) begin
      row_cnt  <= row_cnt - 1'b1;
      succ_cnt <= row_cnt;
    end else if (cmd.j_step) begin
      succ_cnt <= succ_cnt + 1'b1;
    end
  end

  // Read data arrives in the cycle after issue
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.issue;
    end
  end

  // Saturating candidate: edge weight plus successor distance
  assign sum     = SW'(edge_rdata[WEIGHT_BITS-1:0]) + SW'(dist_rdata[DIST_BITS-1:0]);
  assign sum_sat = (sum > SW'(DIST_MAX)) ? DIST_MAX : sum[DIST_BITS-1:0];
  assign cand_ok = !edge_rdata[EW-1] && !dist_rdata[DW-1];

  // Row minimum
  always_ff @(posedge clk) begin
    if (cmd.init || cmd.i_step) begin
      best_inf <= 1'b1;
      best     <= '0;
    end else if (rd_valid && cand_ok && (best_inf || sum_sat < best)) begin
      best_inf <= 1'b0;
      best     <= sum_sat;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      shortest_distance <= best_inf ? '0 : best;
      unreachable       <= best_inf;
    end
  end

  // Status
  assign status.clr_last = (clr_addr == AW'(DEPTH - 1));
  assign status.j_last   = (succ_cnt == last_node);
  assign status.i_zero   = (row_cnt == '0);
  assign status.out_free = !out_valid || !out_stall;

endmodule

// ===== sv/multistage_graph_shortest_path_unit.sv =====
// Top level of the multistage graph shortest path unit.
// Depends on mgsp_pkg, mgsp_ctrl, mgsp_datapath (and mgsp_ram below it).
`timescale 1ns / 1ps

// After reset the unit clears its MAX_NODES*MAX_NODES edge matrix memory to
// "absent", one entry per cycle, and holds in_stall high until that pass is
// done; node_count may be written meanwhile. A load transaction (solve_req
// low) writes one matrix entry, so loads stream back to back. A solve
// transaction sweeps the nodes backward from the destination, reading one
// edge entry and one successor distance per cycle from the two memories
// while it scans a row; it keeps the input stalled until its result is in
// the output register, longer if the previous result has not yet been taken.
// The result sits in an output register, so loads may continue while it
// waits. Loads and solves are only accepted in idle, and each solve gives
// exactly one result transaction.

module multistage_graph_shortest_path_unit #(
  parameter int MAX_NODES   = mgsp_pkg::MAX_NODES_DEFAULT,
  parameter int WEIGHT_BITS = mgsp_pkg::WEIGHT_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [mgsp_pkg::COUNT_BITS-1:0]     cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [mgsp_pkg::INDEX_BITS-1:0]     row_index,
  input  logic [mgsp_pkg::INDEX_BITS-1:0]     col_index,
  input  logic [mgsp_pkg::WEIGHT_IN_BITS-1:0] edge_weight,
  input  logic                                edge_absent,
  input  logic                                solve_req,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mgsp_pkg::DIST_BITS-1:0]      shortest_distance,
  output logic                                unreachable
);

  import mgsp_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencer
  mgsp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .solve_req (solve_req),
    .status    (status),
    .in_stall  (in_stall),
    .cmd       (cmd)
  );

  // Storage and arithmetic
  mgsp_datapath #(
    .MAX_NODES   (MAX_NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .row_index         (row_index),
    .col_index         (col_index),
    .edge_weight       (edge_weight),
    .edge_absent       (edge_absent),
    .cmd               (cmd),
    .status            (status),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .shortest_distance (shortest_distance),
    .unreachable       (unreachable)
  );

endmodule

// ===== sv/mgsp_checker.sv =====
// Port-level checks for the multistage graph shortest path unit, bound to
// the top level. Depends on mgsp_pkg.
`timescale 1ns / 1ps

module mgsp_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                solve_req,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [mgsp_pkg::DIST_BITS-1:0]      shortest_distance,
  input logic                                unreachable
);

  // Clearing pass follows reset: no input transaction right after it
  a_clear_after_rst: assert property (@(posedge clk)
    $past(rst) |-> in_stall)
    else $error("input taken right after reset");

  // A solve transaction makes the unit busy
  a_solve_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && solve_req) |=> in_stall)
    else $error("solve did not stall the input");

  // A load transaction leaves the input open
  a_load_open: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && !solve_req) |=> !in_stall)
    else $error("load stalled the input");

  // A new result only comes at the end of a busy solve
  a_result_from_solve: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while idle");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(shortest_distance) && $stable(unreachable)))
    else $error("stalled result changed");

endmodule

bind multistage_graph_shortest_path_unit mgsp_checker u_mgsp_checker (.*);

// ===== tb/sv/multistage_graph_shortest_path_unit_tb.sv =====
// Self-checking testbench for multistage_graph_shortest_path_unit: loads edge matrices,
// requests solves and checks each distance against a built-in shortest path predictor.
// Depends on mgsp_pkg and the unit's RTL.
`timescale 1ns / 1ps

module multistage_graph_shortest_path_unit_tb;
  import mgsp_pkg::*;

  localparam int NODES         = MAX_NODES_DEFAULT;
  localparam int RANDOM_ITEMS  = 500;
  localparam int SETTLE_CYCLES = 4;
  localparam int QUIET_LIMIT   = 5000;
  localparam int LONG_HOLD     = 300;

  typedef struct packed {
    logic [INDEX_BITS-1:0]     row;
    logic [INDEX_BITS-1:0]     col;
    logic [WEIGHT_IN_BITS-1:0] weight;
    logic                      absent;
    logic                      run;
  } edge_item_t;

  typedef struct packed {
    logic [DIST_BITS-1:0] length;
    logic                 no_path;
  } path_result_t;

  // DUT connections
  logic                      clk;
  logic                      rst = 1'b1;
  logic                      cfg_wr_en = 1'b0;
  logic [COUNT_BITS-1:0]     cfg_wr_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [INDEX_BITS-1:0]     row_index = '0;
  logic [INDEX_BITS-1:0]     col_index = '0;
  logic [WEIGHT_IN_BITS-1:0] edge_weight = '0;
  logic                      edge_absent = 1'b0;
  logic                      solve_req = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [DIST_BITS-1:0]      shortest_distance;
  logic                      unreachable;

  // Predictor state: mirror of the edge matrix and the node count register
  logic [WEIGHT_IN_BITS-1:0] weight_mem [NODES*NODES];
  bit                        absent_mem [NODES*NODES];
  logic [COUNT_BITS-1:0]     node_count_model = NODE_COUNT_RESET;

  edge_item_t   pending_items [$];
  path_result_t expected_paths [$];
  edge_item_t   on_wire;

  int  errors = 0;
  int  loads_sent = 0;
  int  solves_sent = 0;
  int  reached = 0;
  int  unreached = 0;
  int  cfg_writes = 0;
  int  random_items = 0;
  int  send_gap = 0;
  int  rcv_gap = 0;
  int  hold_left = 0;
  int  quiet = 0;
  bit  calm = 0;
  bit  long_hold_wanted = 0;
  bit  long_hold_done = 0;

  multistage_graph_shortest_path_unit dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .row_index        (row_index),
    .col_index        (col_index),
    .edge_weight      (edge_weight),
    .edge_absent      (edge_absent),
    .solve_req        (solve_req),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .shortest_distance(shortest_distance),
    .unreachable      (unreachable)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Node count as the block uses it: clamped to 2..NODES
  function automatic int active_node_count();
    if (node_count_model < MIN_NODES) return MIN_NODES;
    if (node_count_model > NODES) return NODES;
    return int'(node_count_model);
  endfunction

  // Backward DP from the last active node; saturating sums, infinity propagates
  function automatic path_result_t shortest_from_source();
    logic [DIST_BITS-1:0] reach_len [NODES];
    bit                   reach_inf [NODES];
    logic [DIST_BITS-1:0] best;
    bit                   best_inf;
    longint               sum;
    int                   n;
    int                   k;
    path_result_t         res;
    n = active_node_count();
    reach_len[n-1] = '0;
    reach_inf[n-1] = 0;
    for (int i = n - 2; i >= 0; i--) begin
      best = '0;
      best_inf = 1;
      for (int j = i + 1; j < n; j++) begin
        k = i * NODES + j;
        if (absent_mem[k] || reach_inf[j]) continue;
        sum = longint'(weight_mem[k]) + longint'(reach_len[j]);
        if (sum > longint'(DIST_MAX)) sum = longint'(DIST_MAX);
        if (best_inf || sum < longint'(best)) begin
          best = sum[DIST_BITS-1:0];
          best_inf = 0;
        end
      end
      reach_len[i] = best;
      reach_inf[i] = best_inf;
    end
    res.no_path = reach_inf[0];
    res.length  = reach_inf[0] ? '0 : reach_len[0];
    return res;
  endfunction

  task automatic push_item(input int r, input int c, input int w, input bit a, input bit s);
    edge_item_t it;
    it.row    = INDEX_BITS'(r);
    it.col    = INDEX_BITS'(c);
    it.weight = WEIGHT_IN_BITS'(w);
    it.absent = a;
    it.run    = s;
    pending_items.push_back(it);
  endtask

  // One graph round: a burst of edge loads, mostly forward edges among the
  // active nodes with some noise, closed by a solve request
  task automatic add_graph_round();
    int n;
    int loads;
    int kind;
    int r;
    int c;
    int w;
    int wk;
    n = active_node_count();
    loads = $urandom_range(1, 12);
    repeat (loads) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        r = $urandom_range(0, n - 2);
        c = r + $urandom_range(1, (n - 1 - r) < 3 ? (n - 1 - r) : 3);
      end else if (kind < 8) begin
        r = $urandom_range(0, n - 2);
        c = $urandom_range(r + 1, n - 1);
      end else begin
        r = $urandom_range(0, 31);
        c = $urandom_range(0, 31);
      end
      wk = $urandom_range(0, 9);
      if (wk < 5) w = $urandom_range(0, 15);
      else if (wk < 8) w = $urandom & 16'hFFFF;
      else w = ($urandom_range(0, 1) == 0) ? 0 : 16'hFFFF;
      push_item(r, c, w, $urandom_range(0, 4) == 0, 1'b0);
    end
    // load fields on a solve are don't-care; fill them randomly
    push_item($urandom_range(0, 31), $urandom_range(0, 31), $urandom & 16'hFFFF,
              $urandom_range(0, 1), 1'b1);
    random_items += loads + 1;
  endtask

  // Block is idle once nothing is queued, driven or outstanding
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_paths.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_node_count(input int v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= COUNT_BITS'(v);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    node_count_model = COUNT_BITS'(v);
    cfg_writes++;
    @(negedge clk);
  endtask

  // Input driver: tracks accepted transactions into the predictor
  always @(posedge clk) begin : input_driver
    path_result_t want;
    int           k;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (on_wire.run) begin
          want = shortest_from_source();
          expected_paths.push_back(want);
          solves_sent++;
        end else begin
          loads_sent++;
          // weight width equals the port width here, so no masking is needed
          if (int'(on_wire.row) < NODES && int'(on_wire.col) < NODES) begin
            k = int'(on_wire.row) * NODES + int'(on_wire.col);
            absent_mem[k] = on_wire.absent;
            weight_mem[k] = on_wire.absent ? '0 : on_wire.weight;
          end
        end
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 17);
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          on_wire = pending_items.pop_front();
          in_valid    <= 1'b1;
          row_index   <= on_wire.row;
          col_index   <= on_wire.col;
          edge_weight <= on_wire.weight;
          edge_absent <= on_wire.absent;
          solve_req   <= on_wire.run;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall generator
  always @(posedge clk) begin : result_monitor
    path_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_paths.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, got distance %0d unreachable %0b",
                   $time, shortest_distance, unreachable);
        end else begin
          want = expected_paths.pop_front();
          if (shortest_distance !== want.length) begin
            errors++;
            $display("%0t: shortest_distance expected %0d, got %0d",
                     $time, want.length, shortest_distance);
          end
          if (unreachable !== want.no_path) begin
            errors++;
            $display("%0t: unreachable expected %0b, got %0b", $time, want.no_path, unreachable);
          end
          if (want.no_path) unreached++;
          else reached++;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (long_hold_wanted && !long_hold_done) begin
        // long hold-off so results back up and the input stalls
        long_hold_done = 1;
        hold_left = LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else if (rcv_gap > 0) begin
        rcv_gap--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        rcv_gap = $urandom_range(0, 17);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("multistage_graph_shortest_path_unit: mismatch");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Main sequence
  initial begin : main_sequence
    int node_settings [] = '{2, 32, 5, 0, 63, 1, 33, 16, 3, 8, 32, 2, 12, 7, 20};
    int p;
    for (int k = 0; k < NODES * NODES; k++) begin
      weight_mem[k] = '0;
      absent_mem[k] = 1;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part at the reset node count of 8
    push_item(0, 0, 0, 0, 1);               // empty matrix: no path
    push_item(0, 7, 16'hFFFF, 0, 0);        // direct edge at max weight
    push_item(0, 0, 0, 0, 1);
    push_item(0, 1, 0, 0, 0);               // zero-weight chain
    push_item(1, 7, 0, 0, 0);
    push_item(0, 0, 0, 0, 1);
    push_item(7, 0, 1, 0, 0);               // backward edge, never used
    push_item(3, 3, 1, 0, 0);               // self loop, never used
    push_item(1, 7, 16'h5A5A, 1, 0);        // removal with a nonzero weight
    push_item(0, 0, 0, 0, 1);
    push_item(31, 31, 16'hFFFF, 0, 0);      // top corner of the matrix
    push_item(0, 31, 16'h8000, 0, 0);       // beyond the active nodes
    push_item(31, 31, 16'hFFFF, 1, 1);      // solve with every load field set
    push_item(1, 2, 7, 0, 0);
    push_item(2, 7, 3, 0, 0);
    push_item(0, 1, 16'hFFFF, 0, 0);
    push_item(0, 0, 0, 0, 1);
    push_item(0, 2, 1, 0, 0);
    push_item(6, 7, 16'hFFFF, 0, 0);
    push_item(0, 6, 16'hFFFF, 0, 0);
    push_item(0, 0, 0, 0, 1);
    push_item(0, 1, 0, 1, 0);
    push_item(0, 2, 0, 1, 0);
    push_item(0, 0, 0, 0, 1);

    // Random phases, each under its own node count
    p = 0;
    while (random_items < RANDOM_ITEMS) begin
      wait_idle();
      write_node_count(node_settings[p % node_settings.size()]);
      if (p == 2) long_hold_wanted = 1;
      if (random_items >= RANDOM_ITEMS - 80) calm = 1;
      repeat (4) add_graph_round();
      p++;
    end
    wait_idle();
    repeat (8) @(negedge clk);

    $display("ran %0d edge loads and %0d solves (%0d with a path, %0d without)",
             loads_sent, solves_sent, reached, unreached);
    $display("across %0d node_count settings, including the clamped extremes", cfg_writes);
    if (errors == 0) begin
      $display("multistage_graph_shortest_path_unit: match");
    end else begin
      $display("multistage_graph_shortest_path_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/mgsp_pkg.sv
sv/mgsp_ram.sv
sv/mgsp_ctrl.sv
sv/mgsp_datapath.sv
sv/multistage_graph_shortest_path_unit.sv
sv/mgsp_checker.sv
tb/sv/multistage_graph_shortest_path_unit_tb.sv
